>>> design/gla_pkg.sv
// Shared constants and the level weight table for the grid locator to
// position converter. Used by gla_accum, gla_split and the top level.
// No dependencies.
package gla_pkg;

  localparam int unsigned LevelsDefault = 6;
  localparam int unsigned AccW          = 24;
  localparam int unsigned DegW          = 9;
  localparam int unsigned MinW          = 13;
  localparam int unsigned SplitStages   = 6;

  localparam logic [AccW-1:0] PosOffset = 24'd5184000;

  localparam logic [16:0] Recip225 = 17'd74566;
  localparam logic [10:0] Recip15  = 11'd1093;
  localparam logic [9:0]  Recip6   = 10'd683;

  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowX = 8'h78;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpX  = 8'h58;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CaseFold = 8'h20;

  function automatic logic [19:0] level_weight(input logic [3:0] lvl);
    logic [19:0] w;
    case (lvl)
      4'd0:    w = 20'd576000;
      4'd1:    w = 20'd57600;
      4'd2:    w = 20'd2400;
      4'd3:    w = 20'd240;
      4'd4:    w = 20'd10;
      4'd5:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

endpackage

>>> design/grid_locator_to_aprs_position.sv
// Top level of the grid locator to position converter: stream ports,
// pipeline control and output packing. Depends on gla_pkg, gla_accum, gla_split.
//
//  channel  | dir | tdata fields (low bit up)                       | tlast
//  s_axis   | in  | char_code[7:0]                                  | last
//  m_axis   | out | lat_south, lat_degrees[7:0], lat_min_centi[12:0],| -
//           |     | lon_west, lon_degrees[8:0], lon_min_centi[12:0] |
//
// One character is taken every cycle while s_axis_tready_o is high; the result for
// the request that carries tlast passes the capture register and six split stages.
// Reset clears the pair state, the sums and the pipeline valid bits.
// A result not taken holds the whole pipeline and drops s_axis_tready_o.
module grid_locator_to_aprs_position #(
  parameter int unsigned Levels = gla_pkg::LevelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code[7:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // lat_south[0], lat_degrees[8:1], lat_min_centi[21:9], lon_west[22],
  // lon_degrees[31:23], lon_min_centi[44:32], zero[47:45]
  output logic [47:0] m_axis_tdata_o
);

  localparam int unsigned Depth = gla_pkg::SplitStages + 1;

  logic                     en, accept;
  logic [Depth-1:0]         v_q;
  logic [gla_pkg::AccW-1:0] lat_next, lon_next;
  logic [gla_pkg::AccW-1:0] lat_cap_q, lon_cap_q;
  logic                     lat_neg, lon_neg;
  logic [gla_pkg::DegW-1:0] lat_deg, lon_deg;
  logic [gla_pkg::MinW-1:0] lat_minc, lon_minc;

  assign en              = !v_q[Depth-1] || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[Depth-1];

  gla_accum #(
    .Levels(Levels)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .char_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .lat_next_o (lat_next),
    .lon_next_o (lon_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Depth-2:0], accept && s_axis_tlast_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_cap_q <= lat_next;
      lon_cap_q <= lon_next;
    end
  end

  gla_split u_lat (
    .clk_i  (clk_i),
    .en_i   (en),
    .acc_i  (lat_cap_q),
    .dbl_i  (1'b0),
    .neg_o  (lat_neg),
    .deg_o  (lat_deg),
    .minc_o (lat_minc)
  );

  gla_split u_lon (
    .clk_i  (clk_i),
    .en_i   (en),
    .acc_i  (lon_cap_q),
    .dbl_i  (1'b1),
    .neg_o  (lon_neg),
    .deg_o  (lon_deg),
    .minc_o (lon_minc)
  );

  assign m_axis_tdata_o = {3'b000, lon_minc, lon_deg, lon_neg,
                           lat_minc, lat_deg[7:0], lat_neg};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with no result pending");

  a_lat_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (lat_minc < 13'd6000))
    else $error("latitude minutes out of range");

  a_lon_min_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (lon_minc < 13'd6000))
    else $error("longitude minutes out of range");

  a_lat_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (lat_deg <= 9'd202))
    else $error("latitude degrees out of range");

endmodule

>>> design/gla_accum.sv
// Character pairing and weighted accumulation of latitude and longitude.
// Depends on gla_pkg.
module gla_accum #(
  parameter int unsigned Levels = gla_pkg::LevelsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                char_i,
  input  logic                      last_i,
  output logic [gla_pkg::AccW-1:0]  lat_next_o,
  output logic [gla_pkg::AccW-1:0]  lon_next_o
);

  logic [gla_pkg::AccW-1:0] lat_acc_q, lat_acc_d;
  logic [gla_pkg::AccW-1:0] lon_acc_q, lon_acc_d;
  logic                     let_vld_q, let_vld_d;
  logic [4:0]               let_val_q, let_val_d;
  logic                     dig_vld_q, dig_vld_d;
  logic [3:0]               dig_val_q, dig_val_d;
  logic [2:0]               lpc_q, lpc_d;
  logic [2:0]               dpc_q, dpc_d;

  logic [7:0]  ch;
  logic        is_let, is_dig, pair_let, pair_dig, add_en;
  logic [4:0]  let_v;
  logic [3:0]  dig_v;
  logic [3:0]  lvl;
  logic [4:0]  x_op, y_op;
  logic [19:0] w;
  logic [24:0] lon_prod, lat_prod;

  always_comb begin
    ch = char_i;
    if (ch >= gla_pkg::CharLowA && ch <= gla_pkg::CharLowX) begin
      ch = ch - gla_pkg::CaseFold;
    end
    is_let   = (ch >= gla_pkg::CharUpA) && (ch <= gla_pkg::CharUpX);
    is_dig   = (ch >= gla_pkg::CharZero) && (ch <= gla_pkg::CharNine);
    let_v    = 5'(ch - gla_pkg::CharUpA);
    dig_v    = 4'(ch - gla_pkg::CharZero);
    pair_let = is_let && let_vld_q;
    pair_dig = is_dig && dig_vld_q;
    lvl      = pair_let ? {lpc_q, 1'b0} : {dpc_q, 1'b1};
    x_op     = pair_let ? let_val_q : {1'b0, dig_val_q};
    y_op     = pair_let ? let_v : {1'b0, dig_v};
    add_en   = (pair_let || pair_dig) && (lvl < 4'(Levels));
    w        = gla_pkg::level_weight(lvl);
    lon_prod = {5'd0, w} * {20'd0, x_op};
    lat_prod = {5'd0, w} * {20'd0, y_op};
  end

  assign lon_next_o = add_en ? lon_acc_q + lon_prod[gla_pkg::AccW-1:0] : lon_acc_q;
  assign lat_next_o = add_en ? lat_acc_q + lat_prod[gla_pkg::AccW-1:0] : lat_acc_q;

  always_comb begin
    lat_acc_d = lat_next_o;
    lon_acc_d = lon_next_o;
    let_vld_d = let_vld_q;
    let_val_d = let_val_q;
    dig_vld_d = dig_vld_q;
    dig_val_d = dig_val_q;
    lpc_d     = lpc_q;
    dpc_d     = dpc_q;
    if (is_let) begin
      dig_vld_d = 1'b0;
      if (let_vld_q) begin
        let_vld_d = 1'b0;
        if (lpc_q != 3'd7) begin
          lpc_d = lpc_q + 3'd1;
        end
      end else begin
        let_vld_d = 1'b1;
        let_val_d = let_v;
      end
    end else if (is_dig) begin
      let_vld_d = 1'b0;
      if (dig_vld_q) begin
        dig_vld_d = 1'b0;
        if (dpc_q != 3'd7) begin
          dpc_d = dpc_q + 3'd1;
        end
      end else begin
        dig_vld_d = 1'b1;
        dig_val_d = dig_v;
      end
    end else begin
      let_vld_d = 1'b0;
      dig_vld_d = 1'b0;
    end
    if (last_i) begin
      lat_acc_d = '0;
      lon_acc_d = '0;
      let_vld_d = 1'b0;
      dig_vld_d = 1'b0;
      lpc_d     = '0;
      dpc_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_acc_q <= '0;
      lon_acc_q <= '0;
      let_vld_q <= 1'b0;
      let_val_q <= '0;
      dig_vld_q <= 1'b0;
      dig_val_q <= '0;
      lpc_q     <= '0;
      dpc_q     <= '0;
    end else if (accept_i) begin
      lat_acc_q <= lat_acc_d;
      lon_acc_q <= lon_acc_d;
      let_vld_q <= let_vld_d;
      let_val_q <= let_val_d;
      dig_vld_q <= dig_vld_d;
      dig_val_q <= dig_val_d;
      lpc_q     <= lpc_d;
      dpc_q     <= dpc_d;
    end
  end

endmodule

>>> design/gla_split.sv
// Pipelined split of one accumulated sum into hemisphere, degrees and
// hundredths of minutes, using constant reciprocals. Depends on gla_pkg.
module gla_split (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [gla_pkg::AccW-1:0]  acc_i,
  input  logic                      dbl_i,
  output logic                      neg_o,
  output logic [gla_pkg::DegW-1:0]  deg_o,
  output logic [gla_pkg::MinW-1:0]  minc_o
);

  logic                     below;
  logic [gla_pkg::AccW-1:0] mag;
  logic [24:0]              a;

  logic        neg1_q, neg2_q, neg3_q, neg4_q, neg5_q, neg6_q;
  logic [16:0] t1_q, t2_q;
  logic [7:0]  l1_q, l2_q, l3_q;
  logic [8:0]  q2_q, d3_q, d4_q, d5_q, d6_q;
  logic [7:0]  r3_q;
  logic [9:0]  u4_q;
  logic [5:0]  low4_q, m4_q, m5_q, s5_q;
  logic [12:0] minc6_q;

  logic [33:0] prod2;
  logic [16:0] qm3, rem3;
  logic [15:0] f4;
  logic [20:0] prod4;
  logic [9:0]  mq5, um5, r5;
  logic [10:0] rs5;
  logic [6:0]  s7;
  logic [5:0]  s_c, m_c;
  logic [8:0]  d_c;
  logic [9:0]  y6;
  logic [19:0] prod6;
  logic [12:0] minc6;

  always_comb begin
    below = acc_i < gla_pkg::PosOffset;
    mag   = below ? gla_pkg::PosOffset - acc_i : acc_i - gla_pkg::PosOffset;
    a     = dbl_i ? {mag, 1'b0} : {1'b0, mag};
  end

  assign prod2 = {17'd0, t1_q} * {17'd0, gla_pkg::Recip225};
  assign qm3   = {8'd0, q2_q} * 17'd225;
  assign rem3  = t2_q - qm3;
  assign f4    = {r3_q, l3_q};
  assign prod4 = {11'd0, f4[15:6]} * {10'd0, gla_pkg::Recip15};

  always_comb begin
    mq5 = {4'd0, m4_q} * 10'd15;
    um5 = u4_q - mq5;
    r5  = {um5[3:0], low4_q};
    rs5 = {1'b0, r5} + 11'd8;
    s7  = rs5[10:4];
    s_c = s7[5:0];
    m_c = m4_q;
    d_c = d4_q;
    if (s7 == 7'd60) begin
      s_c = '0;
      m_c = m4_q + 6'd1;
    end
    if (m_c == 6'd60) begin
      m_c = '0;
      d_c = d4_q + 9'd1;
    end
  end

  always_comb begin
    y6    = {1'b0, s5_q, 3'b000} + {3'b000, s5_q, 1'b0} + 10'd3;
    prod6 = {10'd0, y6} * {10'd0, gla_pkg::Recip6};
    minc6 = {7'd0, m5_q} * 13'd100 + {6'd0, prod6[18:12]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= below && (mag != '0);
      t1_q    <= a[24:8];
      l1_q    <= a[7:0];
      neg2_q  <= neg1_q;
      q2_q    <= prod2[32:24];
      t2_q    <= t1_q;
      l2_q    <= l1_q;
      neg3_q  <= neg2_q;
      d3_q    <= q2_q;
      r3_q    <= rem3[7:0];
      l3_q    <= l2_q;
      neg4_q  <= neg3_q;
      d4_q    <= d3_q;
      u4_q    <= f4[15:6];
      low4_q  <= f4[5:0];
      m4_q    <= prod4[19:14];
      neg5_q  <= neg4_q;
      d5_q    <= d_c;
      m5_q    <= m_c;
      s5_q    <= s_c;
      neg6_q  <= neg5_q;
      d6_q    <= d5_q;
      minc6_q <= minc6;
    end
  end

  assign neg_o  = neg6_q;
  assign deg_o  = d6_q;
  assign minc_o = minc6_q;

endmodule
